// File: rtl/core/lms_pkg.sv
// ----------------------------------------------------------------------------
// lms_pkg
// shared types, constants and helpers of the led matrix / switch scan unit
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam int LMS_ROW_BITS    = 4;
    localparam int LMS_ROWS        = 1 << LMS_ROW_BITS;
    localparam int LMS_MAX_COLUMNS = 32;
    localparam int LMS_PHASES      = 32;
    localparam int LMS_PADDR_W     = 5;

    // commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_LED_ROWS = 3'd1;
    localparam logic [2:0] REG_SW_ROWS  = 3'd2;
    localparam logic [2:0] REG_COLUMNS  = 3'd3;
    localparam logic [2:0] REG_ON       = 3'd4;
    localparam logic [2:0] REG_OFF      = 3'd5;
    localparam logic [2:0] REG_SETTLE   = 3'd6;

    // register reset values
    localparam logic [4:0] RST_LED_ROWS = 5'd16;
    localparam logic [4:0] RST_SW_ROWS  = 5'd16;
    localparam logic [5:0] RST_COLUMNS  = 6'd32;
    localparam logic [7:0] RST_ON       = 8'd50;
    localparam logic [7:0] RST_OFF      = 8'd5;
    localparam logic [7:0] RST_SETTLE   = 8'd1;

    typedef enum logic [2:0] {
        ST_ON  = 3'b001,
        ST_OFF = 3'b010,
        ST_SW  = 3'b100
    } t_stage;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  phase_sel;
        logic [3:0]  row_sel;
        logic [31:0] pattern_bits;
        logic [31:0] column_levels;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  row_code;
        logic        row_led_mode;
        logic        columns_output;
        logic [31:0] column_drive;
        logic        switch_valid;
        logic [3:0]  switch_row;
        logic [31:0] switch_bits;
        logic [31:0] read_bits;
    } t_out_item;

    // row count saturated to 1 .. rows
    function automatic logic [4:0] clamp_rows(input logic [4:0] n);
        logic [4:0] r;
        if (n == 5'd0) begin
            r = 5'd1;
        end else if (n > 5'(LMS_ROWS)) begin
            r = 5'(LMS_ROWS);
        end else begin
            r = n;
        end
        return r;
    endfunction

    // mask of the column lines in use
    function automatic logic [31:0] col_mask(input logic [5:0] n);
        logic [5:0]  c;
        logic [31:0] m;
        c = (n > 6'(LMS_MAX_COLUMNS)) ? 6'(LMS_MAX_COLUMNS) : n;
        if (c == 6'd0) begin
            m = 32'd0;
        end else if (c >= 6'd32) begin
            m = '1;
        end else begin
            m = (32'd1 << c[4:0]) - 32'd1;
        end
        return m;
    endfunction

endpackage

// File: rtl/core/lms_in_if.sv
// ----------------------------------------------------------------------------
// lms_in_if
// valid/ready channel carrying one command item
// ----------------------------------------------------------------------------
interface lms_in_if
    import lms_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/lms_out_if.sv
// ----------------------------------------------------------------------------
// lms_out_if
// valid/ready channel carrying one result item
// ----------------------------------------------------------------------------
interface lms_out_if
    import lms_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/lms_ram.sv
// ----------------------------------------------------------------------------
// lms_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lms_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read returns old data on a same-address write
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/led_matrix_scan_with_switch_read_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_scan_with_switch_read_unit
// led matrix multiplexer with switch matrix scan over shared column lines
// pipeline: an accepted item passes stage 1 and then the output register,
//   which drives o_result.valid; both hold while the receiver holds off
// throughput: one item per cycle through the pattern ram read port, while the
//   receiver takes results
// reset: synchronous, active low; then a clearing pass zeroes the PHASES*16
//   pattern ram entries (512 at the default), no item is taken meanwhile
// ----------------------------------------------------------------------------
module led_matrix_scan_with_switch_read_unit
    import lms_pkg::*;
#(
    parameter int PHASES = LMS_PHASES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    lms_in_if.sink                 i_item,
    lms_out_if.source              o_result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [LMS_PADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    localparam int PH_W  = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam int DEPTH = PHASES * LMS_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // pipeline stage between the ram read and the output register
    typedef struct packed {
        logic                    enable;
        logic [3:0]              row_code;
        t_stage                  stage;
        logic                    fwd;
        logic [31:0]             fwd_data;
        logic                    sample;
        logic [3:0]              sw_row;
        logic [31:0]             sw_bits;
        logic                    is_read;
        logic                    rd_valid;
    } t_s1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic       r_enable;
    logic [4:0] r_led_rows;
    logic [4:0] r_sw_rows;
    logic [5:0] r_columns;
    logic [7:0] r_on;
    logic [7:0] r_off;
    logic [7:0] r_settle;

    logic       cfg_wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_led_rows <= RST_LED_ROWS;
            r_sw_rows  <= RST_SW_ROWS;
            r_columns  <= RST_COLUMNS;
            r_on       <= RST_ON;
            r_off      <= RST_OFF;
            r_settle   <= RST_SETTLE;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ENABLE:   r_enable   <= pwdata[0];
                REG_LED_ROWS: r_led_rows <= pwdata[4:0];
                REG_SW_ROWS:  r_sw_rows  <= pwdata[4:0];
                REG_COLUMNS:  r_columns  <= pwdata[5:0];
                REG_ON:       r_on       <= pwdata[7:0];
                REG_OFF:      r_off      <= pwdata[7:0];
                REG_SETTLE:   r_settle   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ENABLE:   prdata = {31'd0, r_enable};
            REG_LED_ROWS: prdata = {27'd0, r_led_rows};
            REG_SW_ROWS:  prdata = {27'd0, r_sw_rows};
            REG_COLUMNS:  prdata = {26'd0, r_columns};
            REG_ON:       prdata = {24'd0, r_on};
            REG_OFF:      prdata = {24'd0, r_off};
            REG_SETTLE:   prdata = {24'd0, r_settle};
            default:      prdata = 32'd0;
        endcase
    end

    logic [31:0] mask;
    assign mask = col_mask(r_columns);

    // ------------------------------------------------------------------
    // handshake and pipeline control
    // ------------------------------------------------------------------
    logic        r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic        r_s1_valid;
    t_s1         r_s1;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        s1_adv;
    logic        acc;
    logic        acc_tick;
    t_in_item    item;

    assign item          = i_item.data;
    assign s1_adv        = r_s1_valid && (!r_out_valid || o_result.ready);
    // the clearing pass owns the ram write port, so no item enters meanwhile
    assign i_item.ready  = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign acc           = i_item.valid && i_item.ready;
    assign acc_tick      = acc && (item.cmd == CMD_TICK);

    // ------------------------------------------------------------------
    // scan sequencer
    // ------------------------------------------------------------------
    logic [PH_W-1:0] r_phase, n_phase;
    t_stage          r_stage, n_stage;
    logic [3:0]      r_row, n_row;
    logic [7:0]      r_tick, n_tick;
    logic            sample;

    logic [8:0] tick_inc;
    logic [7:0] on_len;
    logic       led_more;
    logic       sw_more;

    assign tick_inc = {1'b0, r_tick} + 9'd1;
    // zero on time still lights for one tick
    assign on_len   = (r_on == 8'd0) ? 8'd1 : r_on;
    assign led_more = ({1'b0, r_row} + 5'd1) < clamp_rows(r_led_rows);
    assign sw_more  = ({1'b0, r_row} + 5'd1) < clamp_rows(r_sw_rows);

    always_comb begin
        n_phase = r_phase;
        n_stage = r_stage;
        n_row   = r_row;
        n_tick  = r_tick;
        sample  = 1'b0;
        if (cfg_wr && (reg_idx == REG_ENABLE) && !pwdata[0]) begin
            // disabling parks the sequencer at its start point
            n_phase = '0;
            n_stage = ST_ON;
            n_row   = 4'd0;
            n_tick  = 8'd0;
        end else if (acc_tick) begin
            if (!r_enable) begin
                n_phase = '0;
                n_stage = ST_ON;
                n_row   = 4'd0;
                n_tick  = 8'd0;
            end else begin
                case (r_stage)
                    ST_ON: begin
                        if (tick_inc >= {1'b0, on_len}) begin
                            n_tick = 8'd0;
                            if (r_off != 8'd0) begin
                                n_stage = ST_OFF;
                            end else if (led_more) begin
                                n_row   = r_row + 4'd1;
                                n_stage = ST_ON;
                            end else begin
                                n_row   = 4'd0;
                                n_stage = ST_SW;
                            end
                        end else begin
                            n_tick = tick_inc[7:0];
                        end
                    end
                    ST_OFF: begin
                        if (tick_inc >= {1'b0, r_off}) begin
                            n_tick = 8'd0;
                            if (led_more) begin
                                n_row   = r_row + 4'd1;
                                n_stage = ST_ON;
                            end else begin
                                n_row   = 4'd0;
                                n_stage = ST_SW;
                            end
                        end else begin
                            n_tick = tick_inc[7:0];
                        end
                    end
                    ST_SW: begin
                        if (r_tick < r_settle) begin
                            n_tick = r_tick + 8'd1;
                        end else begin
                            // settled: capture this switch row
                            sample = 1'b1;
                            n_tick = 8'd0;
                            if (sw_more) begin
                                n_row = r_row + 4'd1;
                            end else begin
                                n_row   = 4'd0;
                                n_stage = ST_ON;
                                n_phase = (r_phase == PH_W'(PHASES - 1)) ? '0
                                                                         : r_phase + 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_stage = ST_ON;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_stage <= ST_ON;
            r_row   <= 4'd0;
            r_tick  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_stage <= n_stage;
            r_row   <= n_row;
            r_tick  <= n_tick;
        end
    end

    // ------------------------------------------------------------------
    // pattern ram: written by commands and the clearing pass, read at the
    // entry of the current phase and row
    // ------------------------------------------------------------------
    logic          pat_wr;
    logic          phase_ok;
    logic [AW-1:0] pat_waddr;
    logic [AW-1:0] pat_raddr;
    logic          pat_we;
    logic [AW-1:0] pat_ram_waddr;
    logic [31:0]   pat_wdata;
    logic [31:0]   pat_rdata;

    assign phase_ok      = 32'(item.phase_sel) < 32'(PHASES);
    assign pat_wr        = acc && (item.cmd == CMD_WRITE) && phase_ok;
    assign pat_waddr     = AW'({PH_W'(item.phase_sel), item.row_sel});
    assign pat_raddr     = AW'({r_phase, r_row});
    assign pat_we        = r_clr_busy || pat_wr;
    assign pat_ram_waddr = r_clr_busy ? r_clr_addr : pat_waddr;
    assign pat_wdata     = r_clr_busy ? 32'd0 : item.pattern_bits;

    lms_ram #(
        .WIDTH  (32),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (pat_ram_waddr),
        .i_wdata (pat_wdata),
        .i_re    (acc),
        .i_raddr (pat_raddr),
        .o_rdata (pat_rdata)
    );

    // clearing pass after reset, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // switch status ram, entries read as zero until first captured
    // ------------------------------------------------------------------
    logic [LMS_ROWS-1:0] r_sw_written;
    logic [31:0]         sw_wdata;
    logic [31:0]         sw_rdata;
    logic                sw_re;

    assign sw_wdata = item.column_levels & mask;
    assign sw_re    = acc && (item.cmd == CMD_READ);

    lms_ram #(
        .WIDTH  (32),
        .DEPTH  (LMS_ROWS),
        .ADDR_W (LMS_ROW_BITS)
    ) u_switch_ram (
        .i_clk   (i_clk),
        .i_we    (sample),
        .i_waddr (r_row),
        .i_wdata (sw_wdata),
        .i_re    (sw_re),
        .i_raddr (item.row_sel),
        .o_rdata (sw_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_written <= '0;
        end else if (sample) begin
            r_sw_written[r_row] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: ram data arrives, pins are formed
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1.enable   <= r_enable;
            r_s1.row_code <= r_enable ? r_row : 4'(LMS_ROWS - 1);
            r_s1.stage    <= r_stage;
            // a write to the entry being shown bypasses the ram read
            r_s1.fwd      <= pat_wr && (pat_waddr == pat_raddr);
            r_s1.fwd_data <= item.pattern_bits;
            r_s1.sample   <= sample;
            r_s1.sw_row   <= r_row;
            r_s1.sw_bits  <= sw_wdata;
            r_s1.is_read  <= sw_re;
            r_s1.rd_valid <= r_sw_written[item.row_sel];
        end
    end

    t_out_item   res;
    logic [31:0] pat_word;

    assign pat_word = r_s1.fwd ? r_s1.fwd_data : pat_rdata;

    always_comb begin
        res                = '0;
        res.row_code       = r_s1.row_code;
        if (r_s1.enable && (r_s1.stage != ST_SW)) begin
            res.row_led_mode   = (r_s1.stage == ST_ON);
            res.columns_output = 1'b1;
            res.column_drive   = ~pat_word & mask;
        end
        if (r_s1.sample) begin
            res.switch_valid = 1'b1;
            res.switch_row   = r_s1.sw_row;
            res.switch_bits  = r_s1.sw_bits;
        end
        if (r_s1.is_read && r_s1.rd_valid) begin
            res.read_bits = sw_rdata;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= res;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a disabled scan always sits at its start point
    a_disabled_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enable |-> (r_phase == '0 && r_stage == ST_ON && r_row == 4'd0 &&
                       r_tick == 8'd0))
        else $error("sequencer not parked while disabled");

    // no item may enter while stage 1 and the output register are both held
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_result.ready) |-> !i_item.ready)
        else $error("item accepted into a full pipeline");

    // a captured switch row is marked written
    a_capture_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample |=> r_sw_written[$past(r_row)])
        else $error("switch row captured but not marked");

endmodule
